// ===== src/odw_pkg.sv =====
// Shared constants, types and tables for the overdrive waveshaper.
`timescale 1ns / 1ps
`default_nettype none

package odw_pkg;

    // field widths
    localparam int SW = 24;                 // sample width, in and out
    localparam int AW = 24;                 // input magnitude, holds 2^23
    localparam int XW = 40;                 // CORDIC x/y datapath
    localparam int ZW = 27;                 // CORDIC angle accumulator
    localparam int MW = 23;                 // overdrive magnitude, up to 2^22
    localparam int PW = 25;                 // signed magnitude before sign restore
    localparam int MIXW = 10;
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 10;

    // pipeline shape
    localparam int ITERS = 24;              // CORDIC iterations, one per stage
    localparam int LAST = ITERS + 2;        // index of the output stage
    localparam int HARD_LAT = 5;            // overdrive stages before its delay line

    // register indexes
    localparam logic [CFG_IW-1:0] CFG_DYN = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_MIX = 1'b1;

    localparam logic [MIXW-1:0] MIX_THR = 10'd819;

    localparam logic signed [XW-1:0] X0 = 40'sd1073741824;   // 1.0 at 30 fraction bits
    localparam logic [MW-1:0] ONE_Q22 = 23'd4194304;

    // overdrive segments
    localparam logic [1:0] SEG_LOW  = 2'd0;
    localparam logic [1:0] SEG_MID  = 2'd1;
    localparam logic [1:0] SEG_HIGH = 2'd2;

    // ceil(2^26/3), exact floor(n/3) for n < 2^25
    localparam logic [24:0] RECIP3 = 25'd22369622;
    localparam int RECIP3_SH = 26;

    // atan(2^-i), pi/2 = 2^24
    localparam logic signed [ZW-1:0] ANG [0:ITERS-1] = '{
        27'sd8388608, 27'sd4952084, 27'sd2616545, 27'sd1328199,
        27'sd666677,  27'sd333664,  27'sd166872,  27'sd83441,
        27'sd41721,   27'sd20861,   27'sd10430,   27'sd5215,
        27'sd2608,    27'sd1304,    27'sd652,     27'sd326,
        27'sd163,     27'sd81,      27'sd41,      27'sd20,
        27'sd10,      27'sd5,       27'sd3,       27'sd1
    };

    typedef struct packed {
        logic neg;
        logic zero;
        logic hard;
        logic last;
    } t_side;

endpackage

`default_nettype wire

// ===== src/odw_cordic.sv =====
// Pipelined CORDIC vectoring unit: atan(5a) with one iteration per stage.
`timescale 1ns / 1ps
`default_nettype none

module odw_cordic (
    input  wire logic                              i_clk,
    input  wire logic [odw_pkg::ITERS:1]           i_en,
    input  wire logic [odw_pkg::AW-1:0]            i_a,
    output logic signed [odw_pkg::ZW-1:0]          o_z
);
    import odw_pkg::*;

    logic signed [XW-1:0] r_x [0:ITERS-1];
    logic signed [XW-1:0] r_y [0:ITERS-1];
    logic signed [ZW-1:0] r_z [0:ITERS-1];

    genvar g;
    for (g = 0; g < ITERS; g++) begin : g_iter
        logic signed [XW-1:0] w_x;
        logic signed [XW-1:0] w_y;
        logic signed [ZW-1:0] w_z;
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic signed [ZW-1:0] n_z;

        if (g == 0) begin : g_init
            logic signed [XW-1:0] w_ext;
            // vector (1, 5a) at 30 fraction bits: 5a * 2^10
            assign w_ext = XW'(i_a);
            assign w_x = X0;
            assign w_y = (w_ext <<< 12) + (w_ext <<< 10);
            assign w_z = '0;
        end else begin : g_chain
            assign w_x = r_x[g-1];
            assign w_y = r_y[g-1];
            assign w_z = r_z[g-1];
        end

        always_comb begin
            if (w_y >= 0) begin
                n_x = w_x + (w_y >>> g);
                n_y = w_y - (w_x >>> g);
                n_z = w_z + ANG[g];
            end else begin
                n_x = w_x - (w_y >>> g);
                n_y = w_y + (w_x >>> g);
                n_z = w_z - ANG[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[g+1]) begin
                r_x[g] <= n_x;
                r_y[g] <= n_y;
                r_z[g] <= n_z;
            end
        end
    end

    assign o_z = r_z[ITERS-1];

endmodule

`default_nettype wire

// ===== src/odw_overdrive.sv =====
// Three-piece overdrive magnitude, pipelined and delayed to line up with the CORDIC.
`timescale 1ns / 1ps
`default_nettype none

module odw_overdrive (
    input  wire logic                        i_clk,
    input  wire logic [odw_pkg::ITERS:1]     i_en,
    input  wire logic [odw_pkg::AW-1:0]      i_a,
    output logic [odw_pkg::MW-1:0]           o_mag
);
    import odw_pkg::*;

    // stage 1: 3a, segment, d = 2^21 - 3a
    logic [25:0] w_u;
    logic [25:0] w_diff;
    logic [1:0]  n1_seg;
    logic [1:0]  r1_seg;
    logic [19:0] r1_a;
    logic [19:0] r1_d;

    // stage 2: d^2
    logic [1:0]  r2_seg;
    logic [19:0] r2_a;
    logic [39:0] r2_dd;

    // stage 3: floor((3*2^40 - d^2 + 3*2^17) / 2^18)
    logic [41:0] w_num;
    logic [1:0]  r3_seg;
    logic [19:0] r3_a;
    logic [23:0] r3_n;

    // stage 4: reciprocal multiply for the divide by 3
    logic [1:0]  r4_seg;
    logic [19:0] r4_a;
    logic [48:0] r4_p;

    // stage 5 and the delay taps after it
    logic [MW-1:0] n5_mag;
    logic [MW-1:0] r_mag [HARD_LAT:ITERS];

    assign w_u = 26'(i_a) + {1'b0, i_a, 1'b0};
    assign w_diff = 26'd2097152 - w_u;

    always_comb begin
        if (w_u <= 26'd1048576) begin
            n1_seg = SEG_LOW;
        end else if (w_u > 26'd2097152) begin
            n1_seg = SEG_HIGH;
        end else begin
            n1_seg = SEG_MID;
        end
    end

    assign w_num = 42'd3298534883328 + 42'd393216 - {2'b00, r2_dd};

    always_comb begin
        case (r4_seg)
            SEG_LOW:  n5_mag = {r4_a, 3'b000};
            SEG_MID:  n5_mag = r4_p[RECIP3_SH +: MW];
            SEG_HIGH: n5_mag = ONE_Q22;
            default:  n5_mag = ONE_Q22;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_seg <= n1_seg;
            r1_a   <= i_a[19:0];
            r1_d   <= w_diff[19:0];
        end
        if (i_en[2]) begin
            r2_seg <= r1_seg;
            r2_a   <= r1_a;
            r2_dd  <= 40'(r1_d) * 40'(r1_d);
        end
        if (i_en[3]) begin
            r3_seg <= r2_seg;
            r3_a   <= r2_a;
            r3_n   <= w_num[41:18];
        end
        if (i_en[4]) begin
            r4_seg <= r3_seg;
            r4_a   <= r3_a;
            r4_p   <= 49'(r3_n) * 49'(RECIP3);
        end
        if (i_en[HARD_LAT]) begin
            r_mag[HARD_LAT] <= n5_mag;
        end
    end

    genvar g;
    for (g = HARD_LAT + 1; g <= ITERS; g++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_en[g]) begin
                r_mag[g] <= r_mag[g-1];
            end
        end
    end

    assign o_mag = r_mag[ITERS];

endmodule

`default_nettype wire

// ===== src/overdrive_waveshaper.sv =====
// Top level of the overdrive waveshaper: entry stage, pipeline control, sign and saturation.
`timescale 1ns / 1ps
`default_nettype none

// Shapes one Q3.20 sample into one Q1.22 sample per transaction. Soft mode gives
// (2/pi)*atan(5x) from a 24-stage CORDIC; with dynamic_enable set and mix_level
// above 819 the three-piece overdrive is used instead. The pipeline is 27 register
// stages deep (entry, 24 CORDIC iterations, rounding, sign and clamp). One sample
// is accepted every cycle unless a held-off output has backed the pipeline up to
// the entry stage. Empty stages collapse while the output is stalled.
// Write the registers only while no sample is in flight.
module overdrive_waveshaper (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [odw_pkg::CFG_IW-1:0]      i_cfg_idx,
    input  wire logic [odw_pkg::CFG_DW-1:0]      i_cfg_wdata,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [23:0]                     s_axis_tdata,   // [23:0] sample_in
    input  wire logic                            s_axis_tlast,
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [23:0]                          m_axis_tdata,   // [23:0] sample_out
    output logic                                 m_axis_tlast
);
    import odw_pkg::*;

    logic                 r_dyn;
    logic [MIXW-1:0]      r_mix;

    logic [LAST:0]        r_vld;
    logic [LAST:0]        w_en;

    logic [AW-1:0]        r_a;
    logic [AW-1:0]        w_abs;
    t_side                n_side;
    t_side                r_side [0:LAST-1];

    logic signed [ZW-1:0] w_z;
    logic [MW-1:0]        w_hard;
    logic signed [ZW-1:0] w_zr;
    logic signed [PW-1:0] n_mag;
    logic signed [PW-1:0] r_mag;

    logic signed [PW:0]   w_val;
    logic [SW-1:0]        n_sample;
    logic [SW-1:0]        r_sample;
    logic                 r_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn <= 1'b0;
            r_mix <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DYN: r_dyn <= i_cfg_wdata[0];
                CFG_MIX: r_mix <= i_cfg_wdata[MIXW-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    assign w_en[LAST] = !r_vld[LAST] || m_axis_tready;
    genvar g;
    for (g = 0; g < LAST; g++) begin : g_en
        assign w_en[g] = !r_vld[g] || w_en[g+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];

    // stage 0: magnitude and sideband
    assign w_abs = s_axis_tdata[SW-1] ? AW'(~s_axis_tdata + 24'd1) : s_axis_tdata;

    always_comb begin
        n_side.neg  = s_axis_tdata[SW-1];
        n_side.zero = (s_axis_tdata == '0);
        n_side.hard = r_dyn && (r_mix > MIX_THR);
        n_side.last = s_axis_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a       <= w_abs;
            r_side[0] <= n_side;
        end
    end

    for (g = 1; g < LAST; g++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_en[g]) begin
                r_side[g] <= r_side[g-1];
            end
        end
    end

    odw_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (w_en[ITERS:1]),
        .i_a   (r_a),
        .o_z   (w_z)
    );

    odw_overdrive u_overdrive (
        .i_clk (i_clk),
        .i_en  (w_en[ITERS:1]),
        .i_a   (r_a),
        .o_mag (w_hard)
    );

    // stage LAST-1: round angle to Q1.22 and pick the shaper
    assign w_zr = (w_z + 27'sd2) >>> 2;

    always_comb begin
        if (r_side[ITERS].zero) begin
            n_mag = '0;
        end else if (r_side[ITERS].hard) begin
            n_mag = PW'(w_hard);
        end else begin
            n_mag = w_zr[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[LAST-1]) begin
            r_mag <= n_mag;
        end
    end

    // output stage: restore sign, clamp to 24 bits
    assign w_val = r_side[LAST-1].neg ? -(PW+1)'(r_mag) : (PW+1)'(r_mag);

    always_comb begin
        if (w_val > 26'sd8388607) begin
            n_sample = 24'h7FFFFF;
        end else if (w_val < -26'sd8388608) begin
            n_sample = 24'h800000;
        end else begin
            n_sample = w_val[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[LAST]) begin
            r_sample <= n_sample;
            r_last   <= r_side[LAST-1].last;
        end
    end

    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = r_sample;
    assign m_axis_tlast  = r_last;

`ifndef SYNTHESIS
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline valid bits not cleared by reset");

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[LAST] |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST] && m_axis_tready && !r_vld[LAST-1]) |=> !r_vld[LAST])
        else $error("output transaction repeated");

    a_hard_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST-1] && r_side[LAST-1].hard)
            |-> (r_mag >= 25'sd0 && r_mag <= 25'sd4194304))
        else $error("overdrive magnitude out of range");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_overdrive_waveshaper.sv =====
// Self-checking testbench for overdrive_waveshaper: predicted arctangent and overdrive shaping.
`timescale 1ns / 1ps

module tb_overdrive_waveshaper;

    import odw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int FLUSH_CYCLES   = 40;     // pipeline is 27 deep
    localparam longint MIX_LIMIT  = 819;    // mix_level above this picks the overdrive
    localparam longint Q22_ONE    = 64'sd1 <<< 22;

    // atan(2^-i) with pi/2 = 2^24
    localparam longint ATAN_STEP [24] = '{
        8388608, 4952084, 2616545, 1328199, 666677, 333664, 166872, 83441,
        41721, 20861, 10430, 5215, 2608, 1304, 652, 326,
        163, 81, 41, 20, 10, 5, 3, 1
    };

    // segment edges and range limits of the input
    localparam logic [SW-1:0] CORNER_PTS [12] = '{
        24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'd349525,
        24'd349526, -24'sd349526, 24'd699050, 24'd699051, -24'sd699051, 24'h100000
    };

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          last;
    } t_shaped;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [SW-1:0]     s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [SW-1:0]     m_axis_tdata;
    logic              m_axis_tlast;

    // shadow copy of the registers
    logic              dyn_en = 1'b0;
    logic [MIXW-1:0]   mix_lvl = '0;

    t_shaped           shaped_q [$];
    t_shaped           want;
    int                errors = 0;
    int                idle_cycles = 0;
    int                ready_hold = 0;
    bit                stall_on = 1'b0;
    bit                offering = 1'b0;

    overdrive_waveshaper u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // [23:0] sample_in
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),     // [23:0] sample_out
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shaping predictor

    function automatic longint atan_mag(input longint a);
        longint cx, cy, z, dx, dy;
        if (a == 0) return 0;
        cx = 64'sd1 <<< 30;
        cy = a * 5 * 1024;
        z  = 0;
        for (int i = 0; i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + ATAN_STEP[i];
            end else begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - ATAN_STEP[i];
            end
        end
        return (z + 2) >>> 2;
    endfunction

    function automatic longint overdrive_mag(input longint a);
        longint u, d, num;
        u = 3 * a;
        if (u <= (64'sd1 <<< 20)) return a * 8;
        if (u > (64'sd1 <<< 21)) return Q22_ONE;
        d   = (64'sd1 <<< 21) - u;
        num = 3 * (64'sd1 <<< 40) - d * d;
        return (num + 3 * (64'sd1 <<< 17)) / (3 * (64'sd1 <<< 18));
    endfunction

    function automatic logic [SW-1:0] shape_sample(input logic [SW-1:0] s);
        longint x, a, m;
        x = longint'(signed'(s));
        a = (x < 0) ? -x : x;
        if (dyn_en && longint'(mix_lvl) > MIX_LIMIT)
            m = overdrive_mag(a);
        else
            m = atan_mag(a);
        if (x < 0) m = -m;
        if (m > 8388607) m = 8388607;
        if (m < -8388608) m = -8388608;
        return m[SW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SW-1:0] gen_sample();
        int unsigned mag;
        logic [SW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SW'($urandom());
            4, 5:       mag = $urandom_range(0, 1 << 20);
            6:          mag = ($urandom_range(0, 1) ? 349525 : 699050) + $urandom_range(0, 8) - 4;
            7: begin
                case ($urandom_range(0, 3))
                    0:       mag = 0;
                    1:       mag = 1;
                    2:       mag = 8388607;
                    default: mag = 8388608;
                endcase
            end
            8:          mag = $urandom_range(0, 64);
            default:    mag = $urandom_range(1 << 20, 1 << 22);
        endcase
        v = mag[SW-1:0];
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic send_sample(input logic [SW-1:0] s, input logic l);
        int gap;
        t_shaped e;
        e.sample = shape_sample(s);
        e.last   = l;
        gap = (stall_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            if (offering) s_axis_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        s_axis_tlast  <= l;
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        shaped_q.push_back(e);
    endtask

    // stop offering and wait for every outstanding sample to come back
    task automatic drain();
        if (offering) s_axis_tvalid <= 1'b0;
        offering = 1'b0;
        while (shaped_q.size() != 0) @(posedge i_clk);
    endtask

    // only called with the pipeline empty; upper bits of the enable word are junk
    task automatic set_config(input logic dyn, input logic [MIXW-1:0] mix);
        logic [CFG_DW-1:0] dyn_word;
        dyn_word = {9'($urandom_range(0, 511)), dyn};
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_DYN;
        i_cfg_wdata <= dyn_word;
        @(posedge i_clk);
        dyn_en = dyn;
        i_cfg_idx   <= CFG_MIX;
        i_cfg_wdata <= mix;
        @(posedge i_clk);
        mix_lvl = mix;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_sample(gen_sample(), $urandom_range(0, 7) == 0);
    endtask

    // ------------------------------------------------------------------
    // tests

    task automatic test_reset_defaults();
        stall_on = 1'b0;
        foreach (CORNER_PTS[i]) send_sample(CORNER_PTS[i], i[0]);
    endtask

    task automatic test_overdrive_segments();
        drain();
        set_config(1'b1, 10'd820);
        stall_on = 1'b1;
        foreach (CORNER_PTS[i]) send_sample(CORNER_PTS[i], ~i[0]);
        drain();
        set_config(1'b1, 10'd819);      // at the threshold, still soft
        send_sample(24'd349526, 1'b1);
    endtask

    task automatic test_config_sweep();
        logic       dyns [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        logic [9:0] mixs [6] = '{10'd0, 10'd1023, 10'd1023, 10'd819, 10'd820, 10'd0};
        stall_on = 1'b1;
        foreach (dyns[i]) begin
            drain();
            set_config(dyns[i], mixs[i]);
            send_random(130);
        end
    endtask

    task automatic test_random_config();
        logic [MIXW-1:0] mix;
        stall_on = 1'b1;
        for (int p = 0; p < 3; p++) begin
            mix = $urandom_range(0, 1) ? MIXW'($urandom_range(0, 1023))
                                       : MIXW'($urandom_range(815, 824));
            drain();
            set_config(1'($urandom_range(0, 1)), mix);
            send_random(80);
        end
    endtask

    // sender holds off until the pipeline has emptied, then bursts again
    task automatic test_back_pressure();
        stall_on = 1'b1;
        for (int b = 0; b < 4; b++) begin
            drain();
            send_random(20);
        end
    endtask

    task automatic test_full_rate();
        drain();
        set_config(1'b1, 10'd1000);
        stall_on = 1'b0;
        send_random(60);
    endtask

    // ------------------------------------------------------------------
    // output stall generator

    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (stall_on && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= pick_gap() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (shaped_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual sample %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want = shaped_q.pop_front();
                if (m_axis_tdata !== want.sample) begin
                    errors++;
                    $display("%0t: sample mismatch, expected %h actual %h",
                             $time, want.sample, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d samples outstanding",
                         $time, shaped_q.size());
                $display("** overdrive_waveshaper: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_overdrive_segments();
        test_config_sweep();
        test_random_config();
        test_back_pressure();
        test_full_rate();
        drain();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (errors == 0 && shaped_q.size() == 0) begin
            $display("** overdrive_waveshaper: PASSED **");
        end else begin
            $display("** overdrive_waveshaper: FAILED **");
        end
        $finish;
    end

endmodule

// ===== overdrive_waveshaper.f =====
src/odw_pkg.sv
src/odw_cordic.sv
src/odw_overdrive.sv
src/overdrive_waveshaper.sv
dv/tb_overdrive_waveshaper.sv
